/* rtl/rmq_pkg.sv */
// Shared types and constants of the rotation matrix to quaternion converter.
package rmq_pkg;

    // Normalised magnitude width (largest magnitude lies in [2^29, 2^30))
    localparam int MAG_W   = 30;
    localparam int MAG_TOP = 29;
    // Sum of squares, square root and remainders
    localparam int SUM_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int SREM_W  = 33;
    localparam int DREM_W  = 31;
    localparam int LANES   = 4;

    // Configuration port
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int EPS_W   = 15;
    localparam logic [ADDR_W-1:0] ADDR_TRACE_EPS = 3'd0;
    localparam logic [EPS_W-1:0]  EPS_RESET      = 15'd1;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } out_word_t;

    // Control travelling with each word down the chain
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } ctl_t;

    // Data handed from one square-root cell to the next
    typedef struct packed {
        logic [SUM_W-1:0]            s;
        logic [SREM_W-1:0]           rem;
        logic [ROOT_W-1:0]           root;
        logic [LANES-1:0][MAG_W-1:0] mag;
    } sqrt_word_t;

endpackage

/* rtl/rmq_front.sv */
// Front pipeline: branch selection, magnitudes, normalising shift and sum of squares.
module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  in_word_t         in_data,
    input  logic [EPS_W-1:0] eps,
    output ctl_t             ctl_out,
    output sqrt_word_t       word_out
);

    localparam int VW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int PW = $clog2(VW);
    localparam int XW = VW + MAG_W;
    localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

    // ---------------- stage A: sums, differences, branch flags
    logic signed [VW-1:0] a [9];
    logic signed [VW-1:0] eps_v;
    logic signed [VW-1:0] t_next;
    logic signed [VW-1:0] t_reg;
    logic signed [VW-1:0] d_reg [3];
    logic signed [VW-1:0] e_reg [3];
    logic signed [VW-1:0] p_reg [3];
    logic                 tr_reg, c0_reg, c1_reg;
    logic                 va_reg;

    assign a[0]  = VW'(in_data.m00);
    assign a[1]  = VW'(in_data.m01);
    assign a[2]  = VW'(in_data.m02);
    assign a[3]  = VW'(in_data.m10);
    assign a[4]  = VW'(in_data.m11);
    assign a[5]  = VW'(in_data.m12);
    assign a[6]  = VW'(in_data.m20);
    assign a[7]  = VW'(in_data.m21);
    assign a[8]  = VW'(in_data.m22);
    assign eps_v = signed'(VW'(eps));
    assign t_next = a[0] + a[4] + a[8] + ONE_V;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t_next;
            tr_reg   <= (t_next > eps_v);
            c0_reg   <= (a[0] > a[4]) && (a[0] > a[8]);
            c1_reg   <= (a[4] > a[8]);
            d_reg[0] <= ONE_V + a[0] - a[4] - a[8];
            d_reg[1] <= ONE_V + a[4] - a[0] - a[8];
            d_reg[2] <= ONE_V + a[8] - a[0] - a[4];
            e_reg[0] <= a[5] - a[7];
            e_reg[1] <= a[6] - a[2];
            e_reg[2] <= a[1] - a[3];
            p_reg[0] <= a[3] + a[1];
            p_reg[1] <= a[6] + a[2];
            p_reg[2] <= a[7] + a[5];
        end
    end

    // ---------------- stage B: branch vector, magnitude and sign
    logic signed [VW-1:0] v [LANES];
    logic signed [VW-1:0] dz [3];
    logic [VW-1:0]        magb_reg [LANES];
    logic [LANES-1:0]     negb_reg;
    logic                 vb_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dz[i] = (d_reg[i] < 0) ? '0 : d_reg[i];
        end
        if (tr_reg)
        begin
            v[0] = e_reg[0]; v[1] = e_reg[1]; v[2] = e_reg[2]; v[3] = t_reg;
        end
        else if (c0_reg)
        begin
            v[0] = dz[0]; v[1] = p_reg[0]; v[2] = p_reg[1]; v[3] = -e_reg[0];
        end
        else if (c1_reg)
        begin
            v[0] = p_reg[0]; v[1] = dz[1]; v[2] = p_reg[2]; v[3] = e_reg[1];
        end
        else
        begin
            v[0] = p_reg[1]; v[1] = p_reg[2]; v[2] = dz[2]; v[3] = -e_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                magb_reg[i] <= (v[i] < 0) ? VW'(-v[i]) : VW'(v[i]);
                negb_reg[i] <= (v[i] < 0);
            end
        end
    end

    // ---------------- stage C: largest magnitude
    logic [VW-1:0]    mx01, mx23;
    logic [VW-1:0]    mx_reg;
    logic [VW-1:0]    magc_reg [LANES];
    logic [LANES-1:0] negc_reg;
    logic             vc_reg;

    assign mx01 = (magb_reg[0] > magb_reg[1]) ? magb_reg[0] : magb_reg[1];
    assign mx23 = (magb_reg[2] > magb_reg[3]) ? magb_reg[2] : magb_reg[3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= (mx01 > mx23) ? mx01 : mx23;
            magc_reg <= magb_reg;
            negc_reg <= negb_reg;
        end
    end

    // ---------------- stage D: leading one and shift amount
    logic [PW-1:0]    pos;
    logic             shl_reg;
    logic [4:0]       amt_reg;
    logic [VW-1:0]    magd_reg [LANES];
    ctl_t             ctld_reg;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (mx_reg[i])
            begin
                pos = PW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shl_reg  <= (int'(pos) < MAG_TOP);
            amt_reg  <= (int'(pos) < MAG_TOP) ? 5'(MAG_TOP - int'(pos))
                                               : 5'(int'(pos) - MAG_TOP);
            magd_reg <= magc_reg;
        end
    end

    // ---------------- stage E: normalising shift
    logic [XW-1:0]               magx [LANES];
    logic [LANES-1:0][MAG_W-1:0] mage_reg;
    ctl_t                        ctle_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            magx[i] = XW'(magd_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                mage_reg[i] <= shl_reg ? MAG_W'(magx[i] << amt_reg)
                                       : MAG_W'(magx[i] >> amt_reg);
            end
        end
    end

    // ---------------- stage F: squares
    logic [2*MAG_W-1:0]          sq_reg [LANES];
    logic [LANES-1:0][MAG_W-1:0] magf_reg;
    ctl_t                        ctlf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sq_reg[i] <= mage_reg[i] * mage_reg[i];
            end
            magf_reg <= mage_reg;
        end
    end

    // ---------------- stage G: pair sums
    logic [2*MAG_W:0]            ps_reg [2];
    logic [LANES-1:0][MAG_W-1:0] magg_reg;
    ctl_t                        ctlg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg[0] <= (2*MAG_W+1)'(sq_reg[0]) + (2*MAG_W+1)'(sq_reg[1]);
            ps_reg[1] <= (2*MAG_W+1)'(sq_reg[2]) + (2*MAG_W+1)'(sq_reg[3]);
            magg_reg  <= magf_reg;
        end
    end

    // ---------------- stage H: total, handed to the root chain
    sqrt_word_t word_reg;
    ctl_t       ctlh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg.s    <= SUM_W'(ps_reg[0]) + SUM_W'(ps_reg[1]);
            word_reg.rem  <= '0;
            word_reg.root <= '0;
            word_reg.mag  <= magg_reg;
        end
    end

    // control of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            ctld_reg <= '0;
            ctle_reg <= '0;
            ctlf_reg <= '0;
            ctlg_reg <= '0;
            ctlh_reg <= '0;
        end
        else if (en)
        begin
            va_reg         <= in_valid;
            vb_reg         <= va_reg;
            vc_reg         <= vb_reg;
            ctld_reg.valid <= vc_reg;
            ctld_reg.zero  <= (mx_reg == '0);
            ctld_reg.neg   <= negc_reg;
            ctle_reg       <= ctld_reg;
            ctlf_reg       <= ctle_reg;
            ctlg_reg       <= ctlf_reg;
            ctlh_reg       <= ctlg_reg;
        end
    end

    assign ctl_out  = ctlh_reg;
    assign word_out = word_reg;

endmodule

/* rtl/rmq_sqrt_cell.sv */
// One cell of the square-root chain: settles one bit of the root.
module rmq_sqrt_cell
    import rmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  ctl_t       ctl_in,
    input  sqrt_word_t word_in,
    output ctl_t       ctl_out,
    output sqrt_word_t word_out
);

    logic [SREM_W+1:0] x;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;
    logic              ge;
    ctl_t              ctl_reg;
    sqrt_word_t        word_reg;

    // bring down two bits and try root*4+1
    assign x     = {word_in.rem, word_in.s[SUM_W-1 -: 2]};
    assign trial = {1'b0, word_in.root, 2'b01};
    assign ge    = (x >= trial);
    assign diff  = x - trial;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg.s    <= {word_in.s[SUM_W-3:0], 2'b00};
            word_reg.rem  <= ge ? diff[SREM_W-1:0] : x[SREM_W-1:0];
            word_reg.root <= {word_in.root[ROOT_W-2:0], ge};
            word_reg.mag  <= word_in.mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign word_out = word_reg;

endmodule

/* rtl/rmq_div_cell.sv */
// One cell of the divider chain: one quotient bit for each of the four lanes.
module rmq_div_cell
    import rmq_pkg::*;
#(
    parameter int QW = 15
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  ctl_t                         ctl_in,
    input  logic [ROOT_W-1:0]            norm_in,
    input  logic [LANES-1:0][DREM_W-1:0] rem_in,
    input  logic [LANES-1:0][QW-1:0]     low_in,
    output ctl_t                         ctl_out,
    output logic [ROOT_W-1:0]            norm_out,
    output logic [LANES-1:0][DREM_W-1:0] rem_out,
    output logic [LANES-1:0][QW-1:0]     low_out
);

    logic [DREM_W:0]              x    [LANES];
    logic [DREM_W:0]              diff [LANES];
    logic [LANES-1:0]             ge;
    ctl_t                         ctl_reg;
    logic [ROOT_W-1:0]            norm_reg;
    logic [LANES-1:0][DREM_W-1:0] rem_reg;
    logic [LANES-1:0][QW-1:0]     low_reg;

    // restoring step per lane
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            x[i]    = {rem_in[i], low_in[i][QW-1]};
            ge[i]   = (x[i] >= {1'b0, norm_in});
            diff[i] = x[i] - {1'b0, norm_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            norm_reg <= norm_in;
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[i] <= ge[i] ? diff[i][DREM_W-1:0] : x[i][DREM_W-1:0];
                low_reg[i] <= {low_in[i][QW-2:0], ge[i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign norm_out = norm_reg;
    assign rem_out  = rem_reg;
    assign low_out  = low_reg;

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// Converts one 3x3 rotation matrix (nine signed fixed-point elements with
// FRAC_BITS fraction bits) into a normalised quaternion per word. The trace
// branch is used when m00+m11+m22+1 exceeds trace_epsilon (register at
// address 0, reset 1), otherwise the branch of the largest diagonal element.
// Components are rounded half up and saturated to +-1.0 and the 16-bit range;
// an all-zero vector gives the identity. A new matrix is accepted every
// cycle while the output is not stalled; the chain holds the 31 square-root
// cells and the FRAC_BITS+1 divider cells. A stall at the output holds the
// whole chain.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + MAG_W + 1;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic             adv;
    logic [EPS_W-1:0] eps_reg;
    logic             out_valid_reg;
    out_word_t        out_data_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TRACE_EPS) ? DATA_W'(eps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_TRACE_EPS))
        begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    // front stages
    ctl_t       sq_ctl  [ROOT_W+1];
    sqrt_word_t sq_word [ROOT_W+1];

    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .eps      (eps_reg),
        .ctl_out  (sq_ctl[0]),
        .word_out (sq_word[0])
    );

    // square-root chain
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (sq_ctl[k]),
            .word_in  (sq_word[k]),
            .ctl_out  (sq_ctl[k+1]),
            .word_out (sq_word[k+1])
        );
    end

    // dividend preparation: mag * 2^F + norm/2
    logic [NW-1:0]                num [LANES];
    ctl_t                         dv_ctl  [QW+1];
    logic [ROOT_W-1:0]            dv_norm [QW+1];
    logic [LANES-1:0][DREM_W-1:0] dv_rem  [QW+1];
    logic [LANES-1:0][QW-1:0]     dv_low  [QW+1];
    ctl_t                         prep_ctl_reg;
    logic [ROOT_W-1:0]            prep_norm_reg;
    logic [LANES-1:0][DREM_W-1:0] prep_rem_reg;
    logic [LANES-1:0][QW-1:0]     prep_low_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            num[i] = (NW'(sq_word[ROOT_W].mag[i]) << FRAC_BITS)
                   + NW'(sq_word[ROOT_W].root >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_norm_reg <= sq_word[ROOT_W].root;
            for (int i = 0; i < LANES; i++)
            begin
                prep_rem_reg[i] <= DREM_W'(num[i] >> QW);
                prep_low_reg[i] <= num[i][QW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_ctl_reg <= '0;
        end
        else if (adv)
        begin
            prep_ctl_reg <= sq_ctl[ROOT_W];
        end
    end

    assign dv_ctl[0]  = prep_ctl_reg;
    assign dv_norm[0] = prep_norm_reg;
    assign dv_rem[0]  = prep_rem_reg;
    assign dv_low[0]  = prep_low_reg;

    // divider chain
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        rmq_div_cell #(
            .QW (QW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (dv_ctl[k]),
            .norm_in  (dv_norm[k]),
            .rem_in   (dv_rem[k]),
            .low_in   (dv_low[k]),
            .ctl_out  (dv_ctl[k+1]),
            .norm_out (dv_norm[k+1]),
            .rem_out  (dv_rem[k+1]),
            .low_out  (dv_low[k+1])
        );
    end

    // sign, identity case and saturation
    logic [QW-1:0]      mm  [LANES];
    logic signed [15:0] res [LANES];
    ctl_t               fin;

    assign fin = dv_ctl[QW];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (fin.zero)
            begin
                mm[i] = (i == LANES - 1) ? ONE_Q : '0;
            end
            else
            begin
                mm[i] = (dv_low[QW][i] > ONE_Q) ? ONE_Q : dv_low[QW][i];
            end
            if (fin.neg[i] && !fin.zero)
            begin
                res[i] = (32'(mm[i]) > 32'd32768) ? -16'sd32768 : -signed'(16'(mm[i]));
            end
            else
            begin
                res[i] = (32'(mm[i]) > 32'd32767) ? 16'sd32767 : signed'(16'(mm[i]));
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.quat_x <= res[0];
            out_data_reg.quat_y <= res[1];
            out_data_reg.quat_z <= res[2];
            out_data_reg.quat_w <= res[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/rmq_checker.sv */
// Port-level checks for the converter, bound to the top level.
module rmq_checker
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data,
    input logic      pready
);

    localparam int POS_LIM = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;
    localparam int NEG_LIM = (FRAC_BITS < 15) ? -(1 << FRAC_BITS) : -32768;

    // a held word stays put
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // input side only blocks while a finished word waits
    a_ready : assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stage");

    // components stay within unit magnitude
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_data.quat_x) <= POS_LIM) && (int'(out_data.quat_x) >= NEG_LIM)
                   && (int'(out_data.quat_y) <= POS_LIM) && (int'(out_data.quat_y) >= NEG_LIM)
                   && (int'(out_data.quat_z) <= POS_LIM) && (int'(out_data.quat_z) >= NEG_LIM)
                   && (int'(out_data.quat_w) <= POS_LIM) && (int'(out_data.quat_w) >= NEG_LIM))
        else $error("quaternion component out of range");

    // register port never waits
    a_pready : assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (.*);
